FILE: rtl/cnpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnpb_pkg: shared definitions for the cross neighbour pixel blur
// field widths, register codes, reset sizes, stage payload and lane blend
// ----------------------------------------------------------------------------
package cnpb_pkg;

	// field and register widths
	localparam int PIX_W      = 32;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	// default store sizes
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// reset frame size
	localparam logic [FW_W-1:0] RST_WIDTH  = 11'd320;
	localparam logic [FH_W-1:0] RST_HEIGHT = 13'd480;

	// drops the low bit of every byte lane
	localparam logic [PIX_W-1:0] LANE_MASK = 32'hFEFE_FEFE;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// one item handed to the filter stage
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] center;
		logic             interior;
		logic             frame_end;
	} item_t;

	// per-lane average of two pixels, identical pixels pass unchanged
	function automatic logic [PIX_W-1:0] mix2(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PIX_W-1:0] res;
		if (a == b) begin
			res = a;
		end else begin
			res = ((a & LANE_MASK) >> 1) + ((b & LANE_MASK) >> 1);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/cross_neighbour_pixel_blur.sv
`default_nettype none
// a result passes from its input transfer through the stage one register into the result register
// throughput: one pixel per clock while the filter stage does not stall, limited by the line store write port
// items of input row zero and flush items outside the drain give no result
// reset clears the counters, drain flag and valids and sets the size to 320 x 480
// the line stores are not cleared, so there is no clearing pass after reset
// ----------------------------------------------------------------------------
// cross_neighbour_pixel_blur: cross kernel average blur for rgba32 frames
// raster scan control, two line stores, config registers and filter stage
// ----------------------------------------------------------------------------
module cross_neighbour_pixel_blur #(
	parameter int MAX_WIDTH  = cnpb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cnpb_pkg::DEF_MAX_HEIGHT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire [cnpb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [cnpb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire [cnpb_pkg::PIX_W-1:0]          pixel_in,
	input  wire                                flush,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [cnpb_pkg::PIX_W-1:0]         pixel_out,
	output logic                               frame_end
);
	import cnpb_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int CW = (XW + 1 > FW_W) ? XW + 1 : FW_W;
	localparam int RW = (YW + 1 > FH_W) ? YW + 1 : FH_W;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [XW-1:0]    col_q;
	logic [YW-1:0]    row_q;
	logic             drain_q;
	logic [XW-1:0]    col_d;
	logic [YW-1:0]    row_d;
	logic             drain_d;
	logic [XW-1:0]    col_n;
	logic [XW-1:0]    col_p;
	logic [CW-1:0]    fw_ext;
	logic [CW-1:0]    eff_w;
	logic [RW-1:0]    fh_ext;
	logic [RW-1:0]    eff_h;
	logic [CW-1:0]    x_plus;
	logic [RW-1:0]    y_ext;
	logic             row_last;
	logic             frame_last;
	logic             interior;
	logic             accept;
	logic             emit;
	logic             wr_en;
	logic             filt_stall;
	logic [PIX_W-1:0] rb_c;
	logic [PIX_W-1:0] rb_r;
	logic [PIX_W-1:0] rt_c;
	logic [PIX_W-1:0] rt_l;
	item_t            item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= RST_WIDTH;
			fh_q <= RST_HEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data[FH_W-1:0];
			endcase
		end
	end

	// clamped frame size
	assign fw_ext = CW'(fw_q);
	assign fh_ext = RW'(fh_q);
	assign eff_w  = (fw_q == '0) ? CW'(1) :
		((fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext);
	assign eff_h  = (fh_q == '0) ? RW'(1) :
		((fh_ext > RW'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : fh_ext);

	// position tests
	assign x_plus     = CW'(col_q) + CW'(1);
	assign y_ext      = RW'(row_q);
	assign row_last   = (x_plus >= eff_w);
	assign frame_last = ((y_ext + RW'(1)) >= eff_h);
	assign interior   = (col_q != '0) && (x_plus < eff_w) &&
		(row_q >= YW'(2)) && (y_ext < eff_h);

	// input transfer and result decision
	assign accept   = in_valid && !in_stall;
	assign in_stall = filt_stall;
	assign emit     = drain_q || (!flush && (row_q != '0));
	assign wr_en    = accept && !drain_q && !flush;

	// next scan position
	always_comb begin
		col_d   = col_q;
		row_d   = row_q;
		drain_d = drain_q;
		priority if (!accept) begin
			col_d = col_q;
		end else if (drain_q) begin
			if (row_last) begin
				col_d   = '0;
				row_d   = '0;
				drain_d = 1'b0;
			end else begin
				col_d = col_q + 1'b1;
			end
		end else if (flush) begin
			col_d = col_q;
		end else if (row_last) begin
			col_d = '0;
			if (frame_last) begin
				drain_d = 1'b1;
			end else begin
				row_d = row_q + 1'b1;
			end
		end else begin
			col_d = col_q + 1'b1;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
		end else begin
			col_q   <= col_d;
			row_q   <= row_d;
			drain_q <= drain_d;
		end
	end

	// prefetch addresses for the next column and its neighbours
	assign col_n = (col_d == XW'(MAX_WIDTH - 1)) ? '0 : col_d + 1'b1;
	assign col_p = (col_d == '0) ? XW'(MAX_WIDTH - 1) : col_d - 1'b1;

	// previous row: center and right neighbour
	cnpb_line_store #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (PIX_W)
	) u_row_behind (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (col_q),
		.wr_data   (pixel_in),
		.rd_addr_a (col_d),
		.rd_addr_b (col_n),
		.rd_data_a (rb_c),
		.rd_data_b (rb_r)
	);

	// row before that: up neighbour, and left neighbour already shifted in
	cnpb_line_store #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (PIX_W)
	) u_row_two_behind (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (col_q),
		.wr_data   (rb_c),
		.rd_addr_a (col_d),
		.rd_addr_b (col_p),
		.rd_data_a (rt_c),
		.rd_data_b (rt_l)
	);

	// item for the filter stage
	always_comb begin
		item.pix       = pixel_in;
		item.left      = rt_l;
		item.right     = rb_r;
		item.up        = rt_c;
		item.center    = rb_c;
		item.interior  = interior && !drain_q;
		item.frame_end = drain_q && row_last;
	end

	cnpb_filter u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (in_valid && emit),
		.item       (item),
		.item_stall (filt_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.frame_end  (frame_end)
	);

`ifndef SYNTHESIS
	// the drain starts only at the last pixel of a row
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drain_q) |-> $past(accept && row_last && !flush))
		else $error("drain started away from a row end");

	// the end of the drain rewinds the scan to the frame origin
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(drain_q) |-> ((col_q == '0) && (row_q == '0)))
		else $error("scan not rewound after the final row");

	// column stays inside the line stores
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (CW'(col_q) < CW'(MAX_WIDTH)))
		else $error("column beyond the line store depth");
`endif

endmodule
`default_nettype wire

FILE: rtl/cnpb_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnpb_line_store: one row of pixels
// single write port, two registered read ports, write data forwarded on
// a read of the address written at the same edge
// ----------------------------------------------------------------------------
module cnpb_line_store #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 32
) (
	input  wire                       clk,
	input  wire                       wr_en,
	input  wire [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire [DATA_W-1:0]          wr_data,
	input  wire [$clog2(DEPTH)-1:0]   rd_addr_a,
	input  wire [$clog2(DEPTH)-1:0]   rd_addr_b,
	output logic [DATA_W-1:0]         rd_data_a,
	output logic [DATA_W-1:0]         rd_data_b
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;

	// storage and registered reads with forwarding
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr_a)) begin
			rd_a_q <= wr_data;
		end else begin
			rd_a_q <= mem[rd_addr_a];
		end
		if (wr_en && (wr_addr == rd_addr_b)) begin
			rd_b_q <= wr_data;
		end else begin
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule
`default_nettype wire

FILE: rtl/cnpb_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnpb_filter: neighbour blend and result register
// captures one item per transfer, blends the cross neighbours of interior items and holds
// the result until the downstream side takes it
// ----------------------------------------------------------------------------
module cnpb_filter (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            item_valid,
	input  wire cnpb_pkg::item_t           item,
	output logic                           item_stall,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [cnpb_pkg::PIX_W-1:0]     pixel_out,
	output logic                           frame_end
);
	import cnpb_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic             frame_end_q;
	logic             out_free;
	logic             adv_s1;
	logic             take;
	logic [PIX_W-1:0] blend;

	// handshake between stage one and the result register
	assign out_free   = !out_valid_q || !out_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign take       = item_valid && !item_stall;

	// cross blend, border pixels keep their center value
	always_comb begin
		if (item_s1.interior) begin
			blend = mix2(mix2(item_s1.left, item_s1.right), mix2(item_s1.up, item_s1.pix));
		end else begin
			blend = item_s1.center;
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pixel_q     <= blend;
			frame_end_q <= item_s1.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;
	assign frame_end = frame_end_q;

`ifndef SYNTHESIS
	// a stage one item that moves on always lands in the result register
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("stage one item lost on its way to the result register");

	// upstream is held only while both registers are full
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && out_valid_q))
		else $error("stall raised with free room in the pipeline");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cross neighbour pixel blur
// drives fixed and random frames of pixels with flush padding through the valid/stall
// channels, predicts every filtered pixel and compares results in order
// ----------------------------------------------------------------------------
module tb;
	import cnpb_pkg::*;

	localparam int MAX_W       = DEF_MAX_WIDTH;
	localparam int MAX_H       = DEF_MAX_HEIGHT;
	localparam int RAND_ITEMS  = 750;
	localparam int SETTLE_CYC  = 4;
	localparam int TAIL_CYC    = 8;
	localparam int STALL_LIMIT = 4000;

	// one filtered pixel as it leaves the block
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} blurred_px_t;

	// frame predictor and ordered store of expected pixels
	class blur_scoreboard;
		logic [FW_W-1:0]  width_reg;
		logic [FH_W-1:0]  height_reg;
		logic [PIX_W-1:0] row_behind [MAX_W];
		logic [PIX_W-1:0] row_two_behind [MAX_W];
		int unsigned      col;
		int unsigned      row;
		bit               draining;
		blurred_px_t      expected_px [$];
		int               mismatches;
		int               checked;

		function new();
			width_reg  = RST_WIDTH;
			height_reg = RST_HEIGHT;
			foreach (row_behind[i]) begin
				row_behind[i]     = '0;
				row_two_behind[i] = '0;
			end
			col        = 0;
			row        = 0;
			draining   = 0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH: begin
					width_reg = data[FW_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_reg = data[FH_W-1:0];
				end
				default: ;
			endcase
		endfunction

		// register values clamped to what the line stores hold
		function int unsigned eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_H) return MAX_H;
			return height_reg;
		endfunction

		// lane-wise halved sum, equal words kept as they are
		function logic [PIX_W-1:0] blend(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
			logic [PIX_W-1:0] sum;
			int               lane;
			if (a == b) return a;
			for (lane = 0; lane < PIX_W / 8; lane++) begin
				sum[lane*8 +: 8] = {1'b0, a[lane*8+1 +: 7]} + {1'b0, b[lane*8+1 +: 7]};
			end
			return sum;
		endfunction

		// advance the frame by one accepted item
		function void take_pixel(logic [PIX_W-1:0] pix, logic fl);
			int unsigned      w;
			int unsigned      h;
			int unsigned      x;
			bit               last_col;
			logic [PIX_W-1:0] res;
			w        = eff_width();
			h        = eff_height();
			x        = col % MAX_W;
			last_col = (x + 1 >= w);
			// final row goes out one pixel per accepted item, padding or not
			if (draining) begin
				expected_px.push_back('{pixel: row_behind[x], last: last_col});
				if (last_col) begin
					col      = 0;
					row      = 0;
					draining = 0;
				end else begin
					col = x + 1;
				end
				return;
			end
			// padding outside the drain is dropped
			if (fl) return;
			// the row above the incoming one is emitted
			if (row >= 1) begin
				res = row_behind[x];
				if (row >= 2 && row < h && x >= 1 && x + 1 < w) begin
					res = blend(blend(row_two_behind[x-1], row_behind[x+1]),
						blend(row_two_behind[x], pix));
				end
				expected_px.push_back('{pixel: res, last: 1'b0});
			end
			row_two_behind[x] = row_behind[x];
			row_behind[x]     = pix;
			if (last_col) begin
				col = 0;
				if (row + 1 >= h) draining = 1;
				else row = row + 1;
			end else begin
				col = x + 1;
			end
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) $display("mismatch: %s", what);
		endfunction

		// compare one result transfer against the oldest expected pixel
		function void check_pixel(logic [PIX_W-1:0] pix, logic fe);
			blurred_px_t want;
			checked++;
			if (expected_px.size() == 0) begin
				flag($sformatf("pixel %08h end %0b arrived with nothing expected", pix, fe));
				return;
			end
			want = expected_px.pop_front();
			if (pix !== want.pixel || fe !== want.last) begin
				flag($sformatf("result %0d: expected pixel %08h end %0b, got %08h end %0b",
					checked, want.pixel, want.last, pix, fe));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel_in;
	logic                  flush;
	logic                  out_valid;
	logic                  out_stall;
	logic [PIX_W-1:0]      pixel_out;
	logic                  frame_end;

	blur_scoreboard sb;
	int             idle_cycles = 0;
	int             send_idle_pct = 0;
	int             stall_pct = 0;
	int             px_items = 0;
	int             frames = 0;
	int             resizes = 0;

	cross_neighbour_pixel_blur dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.flush     (flush),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.frame_end (frame_end)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// random back-pressure on the result side
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// observe register writes and transfers on both channels
	always @(posedge clk) begin : observe
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_wr_en) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (in_valid && !in_stall) begin
				sb.take_pixel(pixel_in, flush);
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				sb.check_pixel(pixel_out, frame_end);
				moved = 1'b1;
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// watchdog on a stuck handshake
	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("no transfer for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	function void set_idle_mode(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 67; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 67; end
			default: begin send_idle_pct = 35; stall_pct = 35; end
		endcase
	endfunction

	// one input transfer, called and returning at a falling edge
	task automatic send_item(input logic [PIX_W-1:0] pix, input logic fl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			pixel_in <= $urandom;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		flush    <= fl;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// stop sending and let every expected pixel come out
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_px.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// one whole frame: pixels and stray padding until the drain starts, then padding until it ends
	task automatic run_frame(input logic [CFG_DATA_W-1:0] w_data,
		input logic [CFG_DATA_W-1:0] h_data, input bit set_w, input bit set_h,
		input bit resize_mid);
		int unsigned      sent;
		int unsigned      resize_at;
		logic [FW_W-1:0]  new_w;
		logic [FH_W-1:0]  new_h;
		logic [1:0]       junk;
		sent = 0;
		settle();
		if (set_w) cfg_write(REG_FRAME_WIDTH, w_data);
		if (set_h) cfg_write(REG_FRAME_HEIGHT, h_data);
		set_idle_mode(frames);
		frames++;
		resize_at = $urandom_range(sb.eff_width() * sb.eff_height(), 1);
		while (!sb.draining) begin
			// set a width no larger than the current one and a new height while the frame is open
			if (resize_mid && sent == resize_at) begin
				settle();
				new_w = $urandom_range(sb.eff_width(), 0);
				new_h = $urandom_range(6, 0);
				junk  = $urandom_range(3);
				cfg_write(REG_FRAME_WIDTH, {junk, new_w});
				cfg_write(REG_FRAME_HEIGHT, new_h);
				resizes++;
			end
			if ($urandom_range(99) < 3) begin
				send_item($urandom, 1'b1);
			end else begin
				send_item($urandom, 1'b0);
				sent++;
				px_items++;
			end
		end
		// padding, now and then a stray pixel that also drains
		while (sb.draining) begin
			send_item($urandom, ($urandom_range(99) >= 10));
			px_items++;
		end
	endtask

	// main sequence
	initial begin : main
		logic [PIX_W-1:0]      corner_px [9];
		int                    rand_base;
		int unsigned           w;
		int unsigned           h;
		logic [1:0]            junk;
		logic [CFG_DATA_W-1:0] w_data;
		sb        = new();
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		pixel_in  = '0;
		flush     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// smallest frame with an interior pixel, extreme lane values
		corner_px = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h8080_8080, 32'hFFFF_FFFF,
			32'h0000_0000, 32'hFFFF_FFFF, 32'h0101_0101};
		cfg_write(REG_FRAME_WIDTH, 13'd3);
		cfg_write(REG_FRAME_HEIGHT, 13'd3);
		send_item(32'hDEAD_BEEF, 1'b1);
		foreach (corner_px[i]) send_item(corner_px[i], 1'b0);
		send_item(32'h1234_5678, 1'b0);
		send_item(32'hFEFE_FEFE, 1'b1);
		send_item(32'h0000_0000, 1'b1);
		// single-row frame only leaves through padding
		settle();
		cfg_write(REG_FRAME_WIDTH, 13'd2);
		cfg_write(REG_FRAME_HEIGHT, 13'd1);
		send_item(32'h0101_0101, 1'b0);
		send_item(32'hFEFE_FEFE, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1);
		send_item(32'h0000_0000, 1'b1);

		// random frames, mostly small
		rand_base = px_items;
		while (px_items - rand_base < RAND_ITEMS) begin
			if ($urandom_range(19) == 0) w = 0;
			else if ($urandom_range(9) == 0) w = $urandom_range(32, 9);
			else w = $urandom_range(8, 1);
			h      = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
			junk   = $urandom_range(3);
			w_data = {junk, w[FW_W-1:0]};
			run_frame(w_data, h[CFG_DATA_W-1:0], ($urandom_range(9) != 0),
				($urandom_range(9) != 0), ($urandom_range(3) == 0));
		end

		// zero sizes, both used as one
		run_frame(13'd0, 13'd0, 1'b1, 1'b1, 1'b0);

		// drain what is left, then run on with the result side open
		settle();
		stall_pct = 0;
		repeat (TAIL_CYC) @(negedge clk);

		$display("covered %0d frames with %0d resized mid-frame, %0d pixel and padding items",
			frames, resizes, px_items);
		$display("checked %0d filtered pixels, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
